[rtl/mtdg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the matmul tile descriptor generator.
// No dependencies; imported by every module of the block.
package mtdg_pkg;

    // fixed field widths
    localparam int DIM_W      = 16;                  // matrix and tile dimensions
    localparam int MAXT_W     = 21;                  // tile-count limit register
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (DIM_W > MAXT_W) ? DIM_W : MAXT_W;
    localparam int ORD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int OUT_W      = 32;                  // base and count fields
    localparam int STRIDE_W   = 16;
    localparam int PROD_W     = 2 * DIM_W;           // tiles along M times along N
    localparam int TOT_W      = 3 * DIM_W;           // full tile total
    localparam int DIV_CNT_W  = $clog2(DIM_W);

    localparam logic [MAXT_W-1:0] MAX_TILES_RST = MAXT_W'(1048576);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_K    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_DEPTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ORDER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TILES  = 3'd7;

    // loop order codes; the fourth code walks like ijk
    localparam logic [ORD_W-1:0] ORD_IJK = 2'd0;
    localparam logic [ORD_W-1:0] ORD_IKJ = 2'd1;
    localparam logic [ORD_W-1:0] ORD_JIK = 2'd2;

    // result status
    typedef enum logic [STAT_W-1:0] {
        ST_TILE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_DONE    = 2'd2
    } t_status;

    // which dimension the shared divider works on
    typedef enum logic [1:0] {
        SEL_ROWS  = 2'd0,
        SEL_COLS  = 2'd1,
        SEL_DEPTH = 2'd2
    } t_dim_sel;

    // controller -> datapath
    typedef struct packed {
        logic     div_start;     // launch a tile-count division
        logic     div_capture;   // store rounded-up quotient as trip count
        t_dim_sel div_sel;
        logic     clear_active;  // restart drops the running sequence
        logic     mul_p;         // rows x cols trip product
        logic     mul_t;         // times depth trips
        logic     start_seq;     // load counters, mark sequence active
        logic     emit_prep;     // first emit stage: clamps and row product
        logic     load_out;      // write output register
        t_status  out_status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cfg_zero;      // some size or tile extent is zero
        logic active;        // a sequence is running
        logic seq_done;      // every tile of the sequence went out
        logic div_done;
        logic over_limit;    // tile total above max_tiles
        logic out_free;      // output register can take a result this cycle
    } t_sts;

endpackage

[rtl/matmul_tile_descriptor_generator.sv]
`timescale 1ns / 1ps
// Top level of the tiled matmul descriptor generator.
// Depends on mtdg_pkg; instantiates mtdg_ctrl and mtdg_dp.
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_restart      | item in
//  out     | o_out_valid, i_out_ready, o_status ... | item out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data      | write only
//
// Advance item: after accept the two emit states run and the result is registered; the next
// item is taken only once back in idle. Status-only results are loaded from the finish state.
// Restart item: three divisions (16 steps each) on the one shared divider, two multiply
// states, a limit check and the two emit states, in that order.
// Reset is synchronous, active low; the limit register resets to 1048576, others to 0.
// A full output register stalls the final emit step and the status-only finish step; new items wait in idle.
module matmul_tile_descriptor_generator #(
    parameter int INDEX_WIDTH = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mtdg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtdg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mtdg_pkg::STAT_W-1:0]     o_status,
    output logic [INDEX_WIDTH-1:0]          o_tile_index,
    output logic [mtdg_pkg::OUT_W-1:0]      o_base,
    output logic [mtdg_pkg::OUT_W-1:0]      o_count,
    output logic [mtdg_pkg::STRIDE_W-1:0]   o_stride_a,
    output logic [mtdg_pkg::STRIDE_W-1:0]   o_stride_b,
    output logic                            o_last
);
    import mtdg_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    mtdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_restart  (i_restart),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mtdg_dp #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_tile_index (o_tile_index),
        .o_base       (o_base),
        .o_count      (o_count),
        .o_stride_a   (o_stride_a),
        .o_stride_b   (o_stride_b),
        .o_last       (o_last)
    );

endmodule

[rtl/mtdg_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on mtdg_pkg for the operand width.
module mtdg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mtdg_pkg::DIM_W-1:0] i_dividend,
    input  logic [mtdg_pkg::DIM_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [mtdg_pkg::DIM_W-1:0] o_quot,
    output logic [mtdg_pkg::DIM_W-1:0] o_rem
);
    import mtdg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0]     r_quo;
    logic [DIM_W-1:0]     r_rem;
    logic [DIM_W-1:0]     r_dsr;

    logic [DIM_W:0]       w_shift;
    logic [DIM_W:0]       w_diff;
    logic                 w_qbit;

    // shift in next dividend bit and try a subtract
    assign w_shift = {r_rem, r_quo[DIM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_qbit  = !w_diff[DIM_W];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[DIM_W-1:0] : w_shift[DIM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done longer than one cycle");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> (r_done && !r_busy))
        else $error("divider missed its done pulse");
`endif

endmodule

[rtl/mtdg_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the tile descriptor generator: setup, emit and status paths.
// Depends on mtdg_pkg for the command and status structs.
module mtdg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_restart,
    input  mtdg_pkg::t_sts   i_sts,
    output mtdg_pkg::t_cmd   o_cmd
);
    import mtdg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DIV_GO   = 9'b000000010,
        S_DIV_WAIT = 9'b000000100,
        S_MUL1     = 9'b000001000,
        S_MUL2     = 9'b000010000,
        S_CHECK    = 9'b000100000,
        S_EMIT1    = 9'b001000000,
        S_EMIT2    = 9'b010000000,
        S_FIN      = 9'b100000000
    } t_state;

    t_state   r_state, n_state;
    t_dim_sel r_sel, n_sel;
    t_status  r_fin, n_fin;

    logic w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_fin   = r_fin;
        o_cmd   = '0;
        o_cmd.div_sel    = r_sel;
        o_cmd.out_status = ST_TILE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_restart) begin
                        o_cmd.clear_active = 1'b1;
                        if (i_sts.cfg_zero) begin
                            n_fin   = ST_INVALID;
                            n_state = S_FIN;
                        end else begin
                            n_sel   = SEL_ROWS;
                            n_state = S_DIV_GO;
                        end
                    end else if (!i_sts.active) begin
                        n_fin   = ST_INVALID;
                        n_state = S_FIN;
                    end else if (i_sts.seq_done) begin
                        n_fin   = ST_DONE;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_EMIT1;
                    end
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    if (r_sel == SEL_DEPTH) begin
                        n_state = S_MUL1;
                    end else begin
                        n_sel   = (r_sel == SEL_ROWS) ? SEL_COLS : SEL_DEPTH;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul_p = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_t = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.over_limit) begin
                    n_fin   = ST_INVALID;
                    n_state = S_FIN;
                end else begin
                    o_cmd.start_seq = 1'b1;
                    n_state = S_EMIT1;
                end
            end
            S_EMIT1: begin
                o_cmd.emit_prep = 1'b1;
                n_state = S_EMIT2;
            end
            S_EMIT2: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = ST_TILE;
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = r_fin;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_ROWS;
            r_fin   <= ST_INVALID;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_fin   <= n_fin;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("controller stayed idle after taking an item");
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT2 && !i_sts.out_free) |=> (r_state == S_EMIT2))
        else $error("tile result dropped while output was full");
    a_start_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_seq |-> (!i_sts.over_limit && !i_sts.cfg_zero))
        else $error("sequence started on a bad configuration");
`endif

endmodule

[rtl/mtdg_dp.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, trip counts, tile counters, output register.
// Depends on mtdg_pkg and instantiates mtdg_div.
module mtdg_dp #(
    parameter int INDEX_WIDTH = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mtdg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtdg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  mtdg_pkg::t_cmd                  i_cmd,
    output mtdg_pkg::t_sts                  o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [mtdg_pkg::STAT_W-1:0]     o_status,
    output logic [INDEX_WIDTH-1:0]          o_tile_index,
    output logic [mtdg_pkg::OUT_W-1:0]      o_base,
    output logic [mtdg_pkg::OUT_W-1:0]      o_count,
    output logic [mtdg_pkg::STRIDE_W-1:0]   o_stride_a,
    output logic [mtdg_pkg::STRIDE_W-1:0]   o_stride_b,
    output logic                            o_last
);
    import mtdg_pkg::*;

    // configuration
    logic [DIM_W-1:0]  r_rows_m, r_cols_n, r_depth_k;
    logic [DIM_W-1:0]  r_tile_rows, r_tile_cols, r_tile_depth;
    logic [ORD_W-1:0]  r_loop_order;
    logic [MAXT_W-1:0] r_max_tiles;

    // sequence state
    logic              r_active;
    logic [DIM_W-1:0]  r_trip_rows, r_trip_cols, r_trip_depth;
    logic [DIM_W-1:0]  r_ti, r_tj, r_tk;
    logic [DIM_W-1:0]  r_i0, r_j0;
    logic [MAXT_W-1:0] r_emitted, r_total;
    logic [PROD_W-1:0] r_prod_p;
    logic [TOT_W-1:0]  r_prod_t;

    // emit stage
    logic [DIM_W-1:0]  r_rc, r_cc;
    logic [OUT_W-1:0]  r_row_base;

    // output register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [INDEX_WIDTH-1:0] r_out_index;
    logic [OUT_W-1:0]       r_out_base, r_out_count;
    logic [STRIDE_W-1:0]    r_out_stride_a, r_out_stride_b;
    logic                   r_out_last;

    // divider hookup
    logic             w_div_done;
    logic [DIM_W-1:0] w_quot, w_rem, w_ceil;
    logic [DIM_W-1:0] w_dividend, w_divisor;

    // walk control
    logic w_load_tile;
    logic w_wr_i, w_wr_j, w_wr_k;
    logic w_step_i, w_step_j, w_step_k;
    logic w_clr_i, w_clr_j, w_clr_k;
    logic [DIM_W-1:0] w_rem_rows, w_rem_cols;

    // configuration writes end any running sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m     <= '0;
            r_cols_n     <= '0;
            r_depth_k    <= '0;
            r_tile_rows  <= '0;
            r_tile_cols  <= '0;
            r_tile_depth <= '0;
            r_loop_order <= ORD_IJK;
            r_max_tiles  <= MAX_TILES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS_M:     r_rows_m     <= i_cfg_data[DIM_W-1:0];
                CFG_COLS_N:     r_cols_n     <= i_cfg_data[DIM_W-1:0];
                CFG_DEPTH_K:    r_depth_k    <= i_cfg_data[DIM_W-1:0];
                CFG_TILE_ROWS:  r_tile_rows  <= i_cfg_data[DIM_W-1:0];
                CFG_TILE_COLS:  r_tile_cols  <= i_cfg_data[DIM_W-1:0];
                CFG_TILE_DEPTH: r_tile_depth <= i_cfg_data[DIM_W-1:0];
                CFG_LOOP_ORDER: r_loop_order <= i_cfg_data[ORD_W-1:0];
                CFG_MAX_TILES:  r_max_tiles  <= i_cfg_data[MAXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cfg_we || i_cmd.clear_active) begin
            r_active <= 1'b0;
        end else if (i_cmd.start_seq) begin
            r_active <= 1'b1;
        end
    end

    // trip counts: ceil(len / tile) on the shared divider
    always_comb begin
        case (i_cmd.div_sel)
            SEL_ROWS: begin
                w_dividend = r_rows_m;
                w_divisor  = r_tile_rows;
            end
            SEL_COLS: begin
                w_dividend = r_cols_n;
                w_divisor  = r_tile_cols;
            end
            SEL_DEPTH: begin
                w_dividend = r_depth_k;
                w_divisor  = r_tile_depth;
            end
            default: begin
                w_dividend = r_rows_m;
                w_divisor  = r_tile_rows;
            end
        endcase
    end

    mtdg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_ceil = w_quot + DIM_W'(w_rem != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_capture) begin
            case (i_cmd.div_sel)
                SEL_ROWS:  r_trip_rows  <= w_ceil;
                SEL_COLS:  r_trip_cols  <= w_ceil;
                SEL_DEPTH: r_trip_depth <= w_ceil;
                default: begin
                end
            endcase
        end
    end

    // tile total, one multiply per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_p) begin
            r_prod_p <= PROD_W'(r_trip_rows) * PROD_W'(r_trip_cols);
        end
        if (i_cmd.mul_t) begin
            r_prod_t <= TOT_W'(r_prod_p) * TOT_W'(r_trip_depth);
        end
    end

    // loop nest: which counter steps and which wraps, by loop order
    assign w_wr_i = ({1'b0, r_ti} + 1'b1) >= {1'b0, r_trip_rows};
    assign w_wr_j = ({1'b0, r_tj} + 1'b1) >= {1'b0, r_trip_cols};
    assign w_wr_k = ({1'b0, r_tk} + 1'b1) >= {1'b0, r_trip_depth};

    always_comb begin
        case (r_loop_order)
            ORD_IKJ: begin
                w_step_j = 1'b1;
                w_step_k = w_wr_j;
                w_step_i = w_wr_j && w_wr_k;
                w_clr_j  = w_wr_j;
                w_clr_k  = w_wr_j && w_wr_k;
                w_clr_i  = 1'b0;
            end
            ORD_JIK: begin
                w_step_k = 1'b1;
                w_step_i = w_wr_k;
                w_step_j = w_wr_k && w_wr_i;
                w_clr_k  = w_wr_k;
                w_clr_i  = w_wr_k && w_wr_i;
                w_clr_j  = 1'b0;
            end
            default: begin
                w_step_k = 1'b1;
                w_step_j = w_wr_k;
                w_step_i = w_wr_k && w_wr_j;
                w_clr_k  = w_wr_k;
                w_clr_j  = w_wr_k && w_wr_j;
                w_clr_i  = 1'b0;
            end
        endcase
    end

    assign w_load_tile = i_cmd.load_out && (i_cmd.out_status == ST_TILE);

    // counters and running origins, advanced as each tile goes out
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_seq) begin
            r_ti      <= '0;
            r_tj      <= '0;
            r_tk      <= '0;
            r_i0      <= '0;
            r_j0      <= '0;
            r_emitted <= '0;
            r_total   <= r_prod_t[MAXT_W-1:0];
        end else if (w_load_tile) begin
            r_emitted <= r_emitted + 1'b1;
            if (w_clr_i) begin
                r_ti <= '0;
                r_i0 <= '0;
            end else if (w_step_i) begin
                r_ti <= r_ti + 1'b1;
                r_i0 <= r_i0 + r_tile_rows;
            end
            if (w_clr_j) begin
                r_tj <= '0;
                r_j0 <= '0;
            end else if (w_step_j) begin
                r_tj <= r_tj + 1'b1;
                r_j0 <= r_j0 + r_tile_cols;
            end
            if (w_clr_k) begin
                r_tk <= '0;
            end else if (w_step_k) begin
                r_tk <= r_tk + 1'b1;
            end
        end
    end

    // first emit stage: edge clamps and row offset product
    assign w_rem_rows = r_rows_m - r_i0;
    assign w_rem_cols = r_cols_n - r_j0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_prep) begin
            r_rc       <= (r_tile_rows < w_rem_rows) ? r_tile_rows : w_rem_rows;
            r_cc       <= (r_tile_cols < w_rem_cols) ? r_tile_cols : w_rem_cols;
            r_row_base <= OUT_W'(r_i0) * OUT_W'(r_cols_n);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            if (w_load_tile) begin
                r_out_index    <= INDEX_WIDTH'(r_emitted);
                r_out_base     <= r_row_base + OUT_W'(r_j0);
                r_out_count    <= OUT_W'(r_rc) * OUT_W'(r_cc);
                r_out_stride_a <= STRIDE_W'(r_depth_k);
                r_out_stride_b <= STRIDE_W'(r_cols_n);
                r_out_last     <= ((r_emitted + 1'b1) == r_total);
            end else begin
                r_out_index    <= '0;
                r_out_base     <= '0;
                r_out_count    <= '0;
                r_out_stride_a <= '0;
                r_out_stride_b <= '0;
                r_out_last     <= 1'b0;
            end
        end
    end

    // status to the controller
    assign o_sts.cfg_zero   = (r_rows_m == '0) || (r_cols_n == '0) || (r_depth_k == '0) ||
                              (r_tile_rows == '0) || (r_tile_cols == '0) ||
                              (r_tile_depth == '0);
    assign o_sts.active     = r_active;
    assign o_sts.seq_done   = (r_emitted >= r_total);
    assign o_sts.div_done   = w_div_done;
    assign o_sts.over_limit = (r_prod_t > TOT_W'(r_max_tiles));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_tile_index = r_out_index;
    assign o_base       = r_out_base;
    assign o_count      = r_out_count;
    assign o_stride_a   = r_out_stride_a;
    assign o_stride_b   = r_out_stride_b;
    assign o_last       = r_out_last;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before it was taken");
    a_tile_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_tile |-> (r_active && r_emitted < r_total))
        else $error("tile emitted past the end of the sequence");
    a_origin_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_tile |-> (r_i0 < r_rows_m && r_j0 < r_cols_n))
        else $error("running tile origin left the matrix");
`endif

endmodule
